// File: src/framebuffer_pixel_write_assert.svh
// Assertion macros used by the framebuffer pixel write checker.
`ifndef FRAMEBUFFER_PIXEL_WRITE_ASSERT_SVH
`define FRAMEBUFFER_PIXEL_WRITE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define FBPW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fbpw assertion failed");

// Clocked assertion that is checked in reset as well.
`define FBPW_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fbpw assertion failed");

`endif

// File: src/fbpw_pkg.sv
// Shared constants and types of the framebuffer pixel write block.
`default_nettype none

package fbpw_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_ROW_PITCH      = 3'd2;
  localparam logic [2:0] REG_BITS_PER_PIXEL = 3'd3;
  localparam logic [2:0] REG_BUFFER_SIZE    = 3'd4;
  localparam logic [2:0] REG_RED_FORMAT     = 3'd5;
  localparam logic [2:0] REG_GREEN_FORMAT   = 3'd6;
  localparam logic [2:0] REG_BLUE_FORMAT    = 3'd7;

  localparam logic [5:0] BPP_8  = 6'd8;
  localparam logic [5:0] BPP_15 = 6'd15;
  localparam logic [5:0] BPP_16 = 6'd16;
  localparam logic [5:0] BPP_24 = 6'd24;
  localparam logic [5:0] BPP_32 = 6'd32;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [17:0] row_pitch;
    logic [2:0]  byte_count;
    logic [12:0] red_format;
    logic [12:0] green_format;
    logic [12:0] blue_format;
    logic        frame_ok;
  } cfg_t;

  // One queued pixel with its bounds verdict.
  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [23:0] pixel_color;
    logic        in_bounds;
  } pixel_t;

endpackage

`default_nettype wire

// File: src/fbpw_pixel_if.sv
// Pixel input channel interface.
`default_nettype none

interface fbpw_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [23:0] pixel_color;

  modport source (output valid, pixel_x, pixel_y, pixel_color, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, output ready);
endinterface

`default_nettype wire

// File: src/fbpw_result_if.sv
// Write result channel interface.
`default_nettype none

interface fbpw_result_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [31:0] byte_offset;
  logic [2:0]  byte_count;
  logic [31:0] pixel_bytes;

  modport source (output valid, write_enable, byte_offset, byte_count, pixel_bytes,
                  input ready);
  modport sink (input valid, write_enable, byte_offset, byte_count, pixel_bytes,
                output ready);
endinterface

`default_nettype wire

// File: src/fbpw_regs.sv
// Configuration register file and frame geometry checks.
`default_nettype none

module fbpw_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fbpw_pkg::ADDR_W-1:0] paddr,
  input  wire logic [fbpw_pkg::DATA_W-1:0] pwdata,
  output logic      [fbpw_pkg::DATA_W-1:0] prdata,
  output fbpw_pkg::cfg_t                  cfg
);

  logic [15:0] frame_width;
  logic [15:0] frame_height;
  logic [17:0] row_pitch;
  logic [5:0]  bits_per_pixel;
  logic [31:0] buffer_size;
  logic [12:0] red_format;
  logic [12:0] green_format;
  logic [12:0] blue_format;
  logic [33:0] frame_bytes;
  logic        pitch_ok;
  logic        buf_ok;
  logic [2:0]  nbytes;
  logic [18:0] row_span;
  logic [2:0]  reg_index;
  logic        wr;

  assign reg_index = paddr[fbpw_pkg::ADDR_W-1:2];
  assign wr        = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= '0;
      frame_height   <= '0;
      row_pitch      <= '0;
      bits_per_pixel <= '0;
      buffer_size    <= '0;
      red_format     <= '0;
      green_format   <= '0;
      blue_format    <= '0;
    end else if (wr) begin
      case (reg_index)
        fbpw_pkg::REG_FRAME_WIDTH:    frame_width    <= pwdata[15:0];
        fbpw_pkg::REG_FRAME_HEIGHT:   frame_height   <= pwdata[15:0];
        fbpw_pkg::REG_ROW_PITCH:      row_pitch      <= pwdata[17:0];
        fbpw_pkg::REG_BITS_PER_PIXEL: bits_per_pixel <= pwdata[5:0];
        fbpw_pkg::REG_BUFFER_SIZE:    buffer_size    <= pwdata[31:0];
        fbpw_pkg::REG_RED_FORMAT:     red_format     <= pwdata[12:0];
        fbpw_pkg::REG_GREEN_FORMAT:   green_format   <= pwdata[12:0];
        fbpw_pkg::REG_BLUE_FORMAT:    blue_format    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      fbpw_pkg::REG_FRAME_WIDTH:    prdata = {16'b0, frame_width};
      fbpw_pkg::REG_FRAME_HEIGHT:   prdata = {16'b0, frame_height};
      fbpw_pkg::REG_ROW_PITCH:      prdata = {14'b0, row_pitch};
      fbpw_pkg::REG_BITS_PER_PIXEL: prdata = {26'b0, bits_per_pixel};
      fbpw_pkg::REG_BUFFER_SIZE:    prdata = buffer_size;
      fbpw_pkg::REG_RED_FORMAT:     prdata = {19'b0, red_format};
      fbpw_pkg::REG_GREEN_FORMAT:   prdata = {19'b0, green_format};
      fbpw_pkg::REG_BLUE_FORMAT:    prdata = {19'b0, blue_format};
      default:                      prdata = '0;
    endcase
  end

  // Bytes per pixel; zero marks an unsupported depth.
  always_comb begin
    case (bits_per_pixel)
      fbpw_pkg::BPP_8:  nbytes = 3'd1;
      fbpw_pkg::BPP_15: nbytes = 3'd2;
      fbpw_pkg::BPP_16: nbytes = 3'd2;
      fbpw_pkg::BPP_24: nbytes = 3'd3;
      fbpw_pkg::BPP_32: nbytes = 3'd4;
      default:          nbytes = 3'd0;
    endcase
  end

  assign row_span = frame_width * nbytes;

  // The buffer check runs over two registered steps: product, then compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes <= '0;
      pitch_ok    <= 1'b0;
      buf_ok      <= 1'b0;
    end else begin
      frame_bytes <= row_pitch * frame_height;
      pitch_ok    <= {1'b0, row_pitch} >= row_span;
      buf_ok      <= {2'b0, buffer_size} >= frame_bytes;
    end
  end

  always_comb begin
    cfg.frame_width  = frame_width;
    cfg.frame_height = frame_height;
    cfg.row_pitch    = row_pitch;
    cfg.byte_count   = nbytes;
    cfg.red_format   = red_format;
    cfg.green_format = green_format;
    cfg.blue_format  = blue_format;
    cfg.frame_ok     = (nbytes != 3'd0) && pitch_ok && buf_ok;
  end

endmodule

`default_nettype wire

// File: src/fbpw_front.sv
// Front end: pixel bounds classification and the pixel queue.
`default_nettype none

module fbpw_front #(
  parameter int DEPTH = fbpw_pkg::FIFO_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  fbpw_pixel_if.sink         pixel_in,
  input  wire fbpw_pkg::cfg_t cfg,
  output fbpw_pkg::pixel_t   head,
  output logic               head_valid,
  input  wire logic          pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  fbpw_pkg::pixel_t entries [DEPTH];
  fbpw_pkg::pixel_t incoming;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             take;

  assign pixel_in.ready = (count != FULL);
  assign push           = pixel_in.valid && pixel_in.ready;
  assign head_valid     = (count != '0);
  assign take           = head_valid && pop;
  assign head           = entries[rd_ptr];

  always_comb begin
    incoming.pixel_x     = pixel_in.pixel_x;
    incoming.pixel_y     = pixel_in.pixel_y;
    incoming.pixel_color = pixel_in.pixel_color;
    incoming.in_bounds   = (pixel_in.pixel_x < cfg.frame_width) &&
                           (pixel_in.pixel_y < cfg.frame_height);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/fbpw_back.sv
// Back end: offset arithmetic, channel scaling and pixel packing.
`default_nettype none

module fbpw_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire fbpw_pkg::pixel_t head,
  input  wire logic            head_valid,
  output logic                 pop,
  input  wire fbpw_pkg::cfg_t  cfg,
  fbpw_result_if.source        result_out
);

  // Bit length of a channel mask.
  function automatic logic [3:0] mask_len(input logic [7:0] mask);
    logic [3:0] len;
    len = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) len = 4'(i + 1);
    end
    return len;
  endfunction

  // Pre-rounded level v*(2^w-1)+127, at most 65152.
  function automatic logic [15:0] level_pre(input logic [7:0] v, input logic [7:0] mask);
    logic [15:0] wide;
    wide = {8'b0, v} << mask_len(mask);
    return wide - {8'b0, v} + 16'd127;
  endfunction

  // Exact n/255 for n below 65280.
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [16:0] sum;
    sum = {1'b0, n} + {9'b0, n[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  function automatic logic [31:0] place(input logic [15:0] level, input logic [12:0] format);
    logic [7:0] scaled;
    scaled = div255(level) & format[7:0];
    return {24'b0, scaled} << format[12:8];
  endfunction

  logic        s1_valid;
  logic        s1_in_bounds;
  logic [31:0] s1_row_base;
  logic [17:0] s1_col_bytes;
  logic [15:0] s1_level_r;
  logic [15:0] s1_level_g;
  logic [15:0] s1_level_b;
  logic [33:0] row_product;
  logic [18:0] col_product;
  logic        s1_adv;
  logic        s2_adv;
  logic        accept_ok;
  logic [31:0] packed_raw;
  logic [31:0] packed_cut;

  assign s2_adv = !result_out.valid || result_out.ready;
  assign s1_adv = !s1_valid || s2_adv;
  assign pop    = s1_adv;

  assign row_product = head.pixel_y * cfg.row_pitch;
  assign col_product = head.pixel_x * cfg.byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && head_valid) begin
      s1_in_bounds <= head.in_bounds;
      s1_row_base  <= row_product[31:0];
      s1_col_bytes <= col_product[17:0];
      s1_level_r   <= level_pre(head.pixel_color[23:16], cfg.red_format[7:0]);
      s1_level_g   <= level_pre(head.pixel_color[15:8], cfg.green_format[7:0]);
      s1_level_b   <= level_pre(head.pixel_color[7:0], cfg.blue_format[7:0]);
    end
  end

  assign accept_ok  = s1_in_bounds && cfg.frame_ok;
  assign packed_raw = place(s1_level_r, cfg.red_format) |
                      place(s1_level_g, cfg.green_format) |
                      place(s1_level_b, cfg.blue_format);

  always_comb begin
    case (cfg.byte_count)
      3'd1:    packed_cut = {24'b0, packed_raw[7:0]};
      3'd2:    packed_cut = {16'b0, packed_raw[15:0]};
      3'd3:    packed_cut = {8'b0, packed_raw[23:0]};
      3'd4:    packed_cut = {8'hFF, packed_raw[23:0]};
      default: packed_cut = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (s2_adv) begin
      result_out.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      result_out.write_enable <= accept_ok;
      result_out.byte_offset  <= accept_ok ? s1_row_base + {14'b0, s1_col_bytes} : '0;
      result_out.byte_count   <= accept_ok ? cfg.byte_count : '0;
      result_out.pixel_bytes  <= accept_ok ? packed_cut : '0;
    end
  end

endmodule

`default_nettype wire

// File: src/framebuffer_pixel_write.sv
// Top level of the framebuffer pixel write block.
//
// Pixels enter on pixel_in, one beat per pixel carrying column, row and a
// 24-bit RGB color. Each pixel yields exactly one beat on result_out: either
// a write with its byte offset, byte count and packed bytes, or a rejection
// with every field zero. The APB port holds the frame geometry, depth and
// channel formats; pready is always high and reads return register values.
// The block takes one pixel per cycle while its queue has room. A result
// beat passes the multiply stage (row times pitch and the channel
// pre-scaling), then the packing stage, which ends in the output register.
// A queue of FIFO_DEPTH entries sits between the bounds check and these
// stages, so pixel_in keeps accepting while result_out is stalled until the
// queue fills, then pixel_in.ready drops; nothing is lost. The frame checks
// (pitch against width, buffer against pitch times height) are registered
// in the register file, the buffer check as a product and then a compare.
// Synchronous reset empties the queue and stages and clears every config
// register, so a zero depth rejects every pixel until software sets it up.
`default_nettype none

module framebuffer_pixel_write #(
  parameter int FIFO_DEPTH = fbpw_pkg::FIFO_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  fbpw_pixel_if.sink                       pixel_in,
  fbpw_result_if.source                    result_out,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fbpw_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [fbpw_pkg::DATA_W-1:0]  pwdata,
  output logic      [fbpw_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  fbpw_pkg::cfg_t   cfg;
  fbpw_pkg::pixel_t head;
  logic             head_valid;
  logic             pop;

  // The register file never inserts wait states.
  assign pready = 1'b1;

  fbpw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Front end classifies each pixel against the frame and queues it.
  fbpw_front #(
    .DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel_in   (pixel_in),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // Back end drains the queue through the multiply and packing stages.
  fbpw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .cfg        (cfg),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

// File: src/fbpw_checker.sv
// Port-level assertion checker for the framebuffer pixel write block.
`default_nettype none

`include "framebuffer_pixel_write_assert.svh"

module fbpw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        write_enable,
  input wire logic [31:0] byte_offset,
  input wire logic [2:0]  byte_count,
  input wire logic [31:0] pixel_bytes,
  input wire logic        pready
);

  `FBPW_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  `FBPW_ASSERT(a_reject_zero, clk, rst, out_valid && !write_enable |-> byte_offset == 32'd0 && byte_count == 3'd0 && pixel_bytes == 32'd0)
  `FBPW_ASSERT(a_count_range, clk, rst, out_valid && write_enable |-> byte_count != 3'd0 && byte_count <= 3'd4)
  `FBPW_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid)
  `FBPW_ASSERT_ALWAYS(a_pready, clk, pready)

endmodule

bind framebuffer_pixel_write fbpw_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .write_enable (result_out.write_enable),
  .byte_offset  (result_out.byte_offset),
  .byte_count   (result_out.byte_count),
  .pixel_bytes  (result_out.pixel_bytes),
  .pready       (pready)
);

`default_nettype wire
